// File: src/radix_digit_converter_assert.svh
// Assertion macros for the radix digit converter; they compile to nothing in synthesis.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled during reset.
`define RDC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("radix_digit_converter: assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RDC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("radix_digit_converter: assertion failed");

`else

`define RDC_ASSERT_IMP(lbl, ante, cons)
`define RDC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: src/rdc_pkg.sv
// Shared types, constants and the digit-to-character function of the radix digit converter.
package rdc_pkg;

	localparam int VALUE_W   = 64;
	localparam int BASE_W    = 8;
	localparam int CHAR_W    = 7;
	localparam int DIGIT_W   = 6;
	localparam int MAX_DIGITS = 64;
	localparam int DIG_AW    = $clog2(MAX_DIGITS);
	localparam int CHUNK_W   = 8;
	localparam int CHUNKS    = VALUE_W / CHUNK_W;
	localparam int CHUNK_CW  = $clog2(CHUNKS);

	localparam logic [BASE_W-1:0] MIN_BASE = 8'd2;
	localparam logic [BASE_W-1:0] MAX_BASE = 8'd36;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;  // 'A'
	localparam logic [DIGIT_W-1:0] DEC_MAX   = 6'd9;
	localparam logic [DIGIT_W-1:0] DEC_RADIX = 6'd10;

	// Control of the shared divider for one cycle.
	typedef struct packed {
		logic load;   // take a new dividend and base
		logic step;   // consume one chunk of the dividend
		logic clr;    // first chunk of a digit: start from a zero remainder
	} div_ctl_t;

	// What the divider produces in the current step.
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;  // remainder after this step
		logic               zero;   // quotient after this step is zero
	} div_sts_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DEC_MAX) begin
			c = CHAR_ALPHA + CHAR_W'(d - DEC_RADIX);
		end else begin
			c = CHAR_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

// File: src/radix_digit_converter.sv
// Top level of the radix digit converter: sequencer, divider, digit store and output register.
//
//  channel  | direction | tdata (low bit up)              | tlast      | tuser
//  ---------+-----------+----------------------------------+------------+---------
//  s_*      | in        | value[63:0], base[71:64]         | -          | -
//  m_*      | out       | digit_char[6:0], zero pad [7]    | last digit | bad_base
//
// Each digit comes from the shared divider, one dividend byte per cycle; once the quotient is
// zero, the digits are read back from the store in reverse order. A bad base skips the divider.
// s_tready is high only while idle; the output register may still hold the last transaction.
// Stalls on m_tready hold the read-back; reset clears the sequencer and the output valid.
`include "radix_digit_converter_assert.svh"

module radix_digit_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // value[63:0], base[71:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // digit_char[6:0], zero [7]
	output logic        m_tlast,
	output logic        m_tuser    // bad_base
);
	import rdc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_ERR
	} state_t;

	localparam logic [CHUNK_CW-1:0] LAST_CHUNK = CHUNK_CW'(CHUNKS - 1);

	state_t              state_q;
	logic [CHUNK_CW-1:0] chunk_q;
	logic [DIG_AW-1:0]   ndig_q;
	logic [DIG_AW-1:0]   ptr_q;
	logic                m_valid_q;
	logic [CHAR_W-1:0]   m_char_q;
	logic                m_last_q;
	logic                m_bad_q;

	logic [VALUE_W-1:0]  in_value;
	logic [BASE_W-1:0]   in_base;
	logic                base_ok;
	logic                in_acc;
	logic                out_free;
	logic                emit_now;
	logic                out_char_ok;
	div_ctl_t            div_ctl;
	div_sts_t            div_sts;
	logic                ram_we;
	logic [DIGIT_W-1:0]  rd_digit;

	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_base  = s_tdata[VALUE_W +: BASE_W];
	assign base_ok  = (in_base >= MIN_BASE) && (in_base <= MAX_BASE);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign emit_now = out_free && ((state_q == ST_EMIT_WR) || (state_q == ST_ERR));

	assign div_ctl.load = in_acc && base_ok;
	assign div_ctl.step = (state_q == ST_DIV);
	assign div_ctl.clr  = (chunk_q == '0);
	assign ram_we       = (state_q == ST_DIV) && (chunk_q == LAST_CHUNK);

	rdc_div_unit u_div (
		.clk   (clk),
		.ctl   (div_ctl),
		.value (in_value),
		.base  (in_base),
		.sts   (div_sts)
	);

	rdc_digit_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ndig_q),
		.wr_data (div_sts.digit),
		.rd_addr (ptr_q),
		.rd_data (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			chunk_q   <= '0;
			ndig_q    <= '0;
			ptr_q     <= '0;
			m_valid_q <= 1'b0;
			m_char_q  <= '0;
			m_last_q  <= 1'b0;
			m_bad_q   <= 1'b0;
		end else begin
			if (emit_now) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						chunk_q <= '0;
						ndig_q  <= '0;
						state_q <= base_ok ? ST_DIV : ST_ERR;
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + 1'b1;
					if (chunk_q == LAST_CHUNK) begin
						// A digit is complete; stop once the quotient reaches zero.
						if (div_sts.zero) begin
							ptr_q   <= ndig_q;
							state_q <= ST_EMIT_RD;
						end else begin
							ndig_q <= ndig_q + 1'b1;
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						m_char_q  <= digit_to_char(rd_digit);
						m_last_q  <= (ptr_q == '0);
						m_bad_q   <= 1'b0;
						if (ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q - 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						m_char_q  <= '0;
						m_last_q  <= 1'b1;
						m_bad_q   <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_char_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_bad_q;

	assign out_char_ok = ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
		((m_tdata >= 8'h41) && (m_tdata <= 8'h5A));

	// An error transaction is a single zero character that closes its run.
	`RDC_ASSERT_IMP(a_err_shape, m_tvalid && m_tuser, (m_tdata == 8'h00) && m_tlast)
	// A digit transaction always carries a digit or an upper-case letter.
	`RDC_ASSERT_IMP(a_digit_char, m_tvalid && !m_tuser, out_char_ok)
	// Once an item is taken, the block works on it before taking another.
	`RDC_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

// File: src/rdc_div_unit.sv
// Shared long-division unit: divides the working word by the base, one byte per cycle.
module rdc_div_unit (
	input  logic                         clk,
	input  rdc_pkg::div_ctl_t            ctl,
	input  logic [rdc_pkg::VALUE_W-1:0]  value,
	input  logic [rdc_pkg::BASE_W-1:0]   base,
	output rdc_pkg::div_sts_t            sts
);
	import rdc_pkg::*;

	logic [VALUE_W-1:0] work_q;
	logic [DIGIT_W-1:0] base_q;
	logic [DIGIT_W-1:0] rem_q;

	logic [DIGIT_W:0]   part;
	logic [DIGIT_W:0]   trial;
	logic [CHUNK_W-1:0] qbits;
	logic [VALUE_W-1:0] work_nxt;

	// Eight restoring steps on the top byte of the working word; the quotient
	// bits shift in at the bottom, so after a full pass the word holds the quotient.
	always_comb begin
		part  = ctl.clr ? '0 : {1'b0, rem_q};
		trial = '0;
		qbits = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			trial = {part[DIGIT_W-1:0], work_q[VALUE_W-1-i]};
			if (trial >= {1'b0, base_q}) begin
				part = trial - {1'b0, base_q};
				qbits[CHUNK_W-1-i] = 1'b1;
			end else begin
				part = trial;
			end
		end
		work_nxt = {work_q[VALUE_W-CHUNK_W-1:0], qbits};
	end

	assign sts.digit = part[DIGIT_W-1:0];
	assign sts.zero  = (work_nxt == '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			work_q <= value;
			base_q <= base[DIGIT_W-1:0];
		end else if (ctl.step) begin
			work_q <= work_nxt;
			rem_q  <= part[DIGIT_W-1:0];
		end
	end

endmodule

// File: src/rdc_digit_ram.sv
// Digit store: one write port and one registered read port.
module rdc_digit_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [rdc_pkg::DIG_AW-1:0]  wr_addr,
	input  logic [rdc_pkg::DIGIT_W-1:0] wr_data,
	input  logic [rdc_pkg::DIG_AW-1:0]  rd_addr,
	output logic [rdc_pkg::DIGIT_W-1:0] rd_data
);
	import rdc_pkg::*;

	logic [DIGIT_W-1:0] mem [MAX_DIGITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
